// ----- rtl/core/hlsp_pkg.sv -----
// Shared types and constants of the hop-limited shortest path block.
`timescale 1ns / 1ps
`default_nettype none

package hlsp_pkg;

  localparam int CITY_W     = 7;
  localparam int CITIES     = 1 << CITY_W;
  localparam int MAX_EDGES  = 8192;
  localparam int EDGE_AW    = $clog2(MAX_EDGES);
  localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
  localparam int PRICE_W    = 14;
  localparam int COST_W     = 21;
  localparam int STOPS_W    = 7;
  localparam int ROUND_W    = STOPS_W + 1;
  localparam int CMD_W      = 2;
  localparam int COST_AW    = CITY_W + 1;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CITY_W-1:0]  from_city;
    logic [CITY_W-1:0]  to_city;
    logic [PRICE_W-1:0] price;
  } edge_t;

  typedef struct packed {
    logic [EDGE_CNT_W-1:0] count;
    logic                  overflow;
  } edge_stat_t;

  typedef struct packed {
    logic               valid;
    logic [CITY_W-1:0]  src;
    logic [CITY_W-1:0]  dst;
    logic [STOPS_W-1:0] stops;
  } query_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/hlsp_ram.sv -----
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module hlsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/hlsp_edge_list.sv -----
// Edge list storage with fill count and dropped-edge flag.
`timescale 1ns / 1ps
`default_nettype none

module hlsp_edge_list (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  hlsp_pkg::cmd_t               cmd,
  input  hlsp_pkg::edge_t              edge_in,
  input  logic [hlsp_pkg::EDGE_AW-1:0] rd_addr,
  output hlsp_pkg::edge_t              rd_data,
  output hlsp_pkg::edge_stat_t         stat
);
  import hlsp_pkg::*;

  logic [EDGE_CNT_W-1:0] count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  we;
  logic                  has_room;

  assign has_room = count_r < EDGE_CNT_W'(MAX_EDGES);

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    we        = 1'b0;
    if (cmd_valid) begin
      case (cmd)
        CMD_CLEAR: begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        CMD_ADD: begin
          if (has_room) begin
            we        = 1'b1;
            count_nxt = count_r + EDGE_CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  hlsp_ram #(
    .WIDTH($bits(edge_t)),
    .DEPTH(MAX_EDGES)
  ) u_edge_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (count_r[EDGE_AW-1:0]),
    .wdata   (edge_in),
    .raddr_a (rd_addr),
    .rdata_a (rd_data),
    .raddr_b (rd_addr),
    .rdata_b ()
  );

  assign stat.count    = count_r;
  assign stat.overflow = ovf_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= EDGE_CNT_W'(MAX_EDGES))
    else $error("edge count beyond capacity");

endmodule

`default_nettype wire

// ----- rtl/core/hlsp_engine.sv -----
// Round-limited relaxation engine over a banked cost memory.
`timescale 1ns / 1ps
`default_nettype none

module hlsp_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hlsp_pkg::query_req_t         req,
  input  hlsp_pkg::edge_stat_t         stat,
  output logic [hlsp_pkg::EDGE_AW-1:0] edge_raddr,
  input  hlsp_pkg::edge_t              edge_rdata,
  output logic                         busy,
  output logic                         out_valid,
  output logic [hlsp_pkg::COST_W-1:0]  out_path_cost,
  output logic                         out_found,
  output logic                         out_edge_overflow
);
  import hlsp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_COPY  = 6'b000100,
    S_EDGE  = 6'b001000,
    S_RDRES = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CITY_W-1:0]     src_r, src_nxt;
  logic [CITY_W-1:0]     dst_r, dst_nxt;
  logic [ROUND_W-1:0]    rounds_r, rounds_nxt;
  logic                  bank_r, bank_nxt;
  logic [CITIES-1:0]     vld_r [2];
  logic [CITIES-1:0]     vld_nxt [2];
  logic [CITY_W:0]       cp_cnt_r, cp_cnt_nxt;
  logic                  cp_v_r, cp_v_nxt;
  logic [CITY_W-1:0]     cp_addr_r, cp_addr_nxt;
  logic [EDGE_CNT_W-1:0] e_cnt_r, e_cnt_nxt;
  logic                  s1_v_r, s1_v_nxt;
  logic                  s2_v_r, s2_v_nxt;
  edge_t                 s2_edge_r, s2_edge_nxt;
  logic                  changed_r, changed_nxt;
  logic                  fw_v_r, fw_v_nxt;
  logic [CITY_W-1:0]     fw_addr_r, fw_addr_nxt;
  logic [COST_W-1:0]     fw_cost_r, fw_cost_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]     out_cost_r, out_cost_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  ram_we;
  logic [COST_AW-1:0]    ram_waddr;
  logic [COST_W-1:0]     ram_wdata;
  logic [COST_AW-1:0]    ram_ra0;
  logic [COST_AW-1:0]    ram_ra1;
  logic [COST_W-1:0]     ram_rd0;
  logic [COST_W-1:0]     ram_rd1;

  logic                  cur_ok;
  logic                  nxt_ok;
  logic [COST_W-1:0]     nxt_cost;
  logic [COST_W:0]       sum;
  logic [COST_W-1:0]     cand;
  logic                  upd;
  logic                  pass_done;

  assign cur_ok   = vld_r[bank_r][s2_edge_r.from_city];
  assign nxt_ok   = vld_r[~bank_r][s2_edge_r.to_city];
  assign nxt_cost = (fw_v_r && fw_addr_r == s2_edge_r.to_city) ? fw_cost_r : ram_rd1;
  assign sum      = {1'b0, ram_rd0} + (COST_W + 1)'(s2_edge_r.price);
  assign cand     = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  assign upd      = s2_v_r && cur_ok && (!nxt_ok || cand < nxt_cost);
  assign pass_done = (e_cnt_r == stat.count) && !s1_v_r && !s2_v_r;

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    rounds_nxt    = rounds_r;
    bank_nxt      = bank_r;
    vld_nxt       = vld_r;
    cp_cnt_nxt    = cp_cnt_r;
    cp_v_nxt      = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    e_cnt_nxt     = e_cnt_r;
    s1_v_nxt      = 1'b0;
    s2_v_nxt      = 1'b0;
    s2_edge_nxt   = s2_edge_r;
    changed_nxt   = changed_r;
    fw_v_nxt      = 1'b0;
    fw_addr_nxt   = fw_addr_r;
    fw_cost_nxt   = fw_cost_r;
    out_valid_nxt = 1'b0;
    out_cost_nxt  = out_cost_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_ra0       = {bank_r, cp_cnt_r[CITY_W-1:0]};
    ram_ra1       = {~bank_r, edge_rdata.to_city};
    edge_raddr    = e_cnt_r[EDGE_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          src_nxt    = req.src;
          dst_nxt    = req.dst;
          rounds_nxt = ROUND_W'(req.stops) + ROUND_W'(1);
          state_nxt  = S_INIT;
        end
      end
      S_INIT: begin
        if (src_r == dst_r) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = '0;
          out_found_nxt = 1'b1;
          out_ovf_nxt   = stat.overflow;
          state_nxt     = S_IDLE;
        end else begin
          ram_we                = 1'b1;
          ram_waddr             = {bank_r, src_r};
          ram_wdata             = '0;
          vld_nxt[bank_r]       = '0;
          vld_nxt[bank_r][src_r] = 1'b1;
          cp_cnt_nxt            = '0;
          state_nxt             = S_COPY;
        end
      end
      S_COPY: begin
        if (cp_cnt_r == '0) begin
          vld_nxt[~bank_r] = vld_r[bank_r];
        end
        if (!cp_cnt_r[CITY_W]) begin
          cp_cnt_nxt  = cp_cnt_r + (CITY_W + 1)'(1);
          cp_v_nxt    = 1'b1;
          cp_addr_nxt = cp_cnt_r[CITY_W-1:0];
        end else begin
          e_cnt_nxt   = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_EDGE;
        end
        if (cp_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = {~bank_r, cp_addr_r};
          ram_wdata = ram_rd0;
        end
      end
      S_EDGE: begin
        if (e_cnt_r < stat.count) begin
          e_cnt_nxt = e_cnt_r + EDGE_CNT_W'(1);
          s1_v_nxt  = 1'b1;
        end
        if (s1_v_r) begin
          ram_ra0     = {bank_r, edge_rdata.from_city};
          s2_v_nxt    = 1'b1;
          s2_edge_nxt = edge_rdata;
        end
        if (upd) begin
          ram_we                              = 1'b1;
          ram_waddr                           = {~bank_r, s2_edge_r.to_city};
          ram_wdata                           = cand;
          vld_nxt[~bank_r][s2_edge_r.to_city] = 1'b1;
          changed_nxt                         = 1'b1;
          fw_v_nxt                            = 1'b1;
          fw_addr_nxt                         = s2_edge_r.to_city;
          fw_cost_nxt                         = cand;
        end
        if (pass_done) begin
          bank_nxt   = ~bank_r;
          rounds_nxt = rounds_r - ROUND_W'(1);
          if (!changed_r || rounds_r == ROUND_W'(1)) begin
            state_nxt = S_RDRES;
          end else begin
            cp_cnt_nxt = '0;
            state_nxt  = S_COPY;
          end
        end
      end
      S_RDRES: begin
        ram_ra0   = {bank_r, dst_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = vld_r[bank_r][dst_r];
        out_cost_nxt  = vld_r[bank_r][dst_r] ? ram_rd0 : '0;
        out_ovf_nxt   = stat.overflow;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rounds_r    <= '0;
      bank_r      <= 1'b0;
      cp_cnt_r    <= '0;
      cp_v_r      <= 1'b0;
      e_cnt_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      changed_r   <= 1'b0;
      fw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rounds_r    <= rounds_nxt;
      bank_r      <= bank_nxt;
      cp_cnt_r    <= cp_cnt_nxt;
      cp_v_r      <= cp_v_nxt;
      e_cnt_r     <= e_cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      changed_r   <= changed_nxt;
      fw_v_r      <= fw_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    vld_r       <= vld_nxt;
    cp_addr_r   <= cp_addr_nxt;
    s2_edge_r   <= s2_edge_nxt;
    fw_addr_r   <= fw_addr_nxt;
    fw_cost_r   <= fw_cost_nxt;
    out_cost_r  <= out_cost_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  hlsp_ram #(
    .WIDTH(COST_W),
    .DEPTH(2 * CITIES)
  ) u_cost_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra0),
    .rdata_a (ram_rd0),
    .raddr_b (ram_ra1),
    .rdata_b (ram_rd1)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_path_cost     = out_cost_r;
  assign out_found         = out_found_r;
  assign out_edge_overflow = out_ovf_r;

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_stage2_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> state_r == S_EDGE)
    else $error("relaxation stage active outside an edge pass");

  a_cur_bank_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_EDGE) |-> ram_waddr[CITY_W] != bank_r)
    else $error("edge pass wrote the current round's costs");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_cost_r == '0)
    else $error("nonzero cost reported for a missing route");

endmodule

`default_nettype wire

// ----- rtl/core/hop_limited_shortest_path_top.sv -----
// Top level of the hop-limited shortest path block.
//
//   Channel  Ports                         Handshake
//   request  start, busy, in_*             accepted when start is high and busy is low
//   result   out_valid, out_*              one-cycle strobe, always taken
//
// Clear and add requests produce no result and leave busy low.
// A query with equal source and target returns cost zero from the init state, without a relaxation pass.
// Other queries run R rounds, at most max_stops + 1 and fewer once a round changes
// nothing; each round copies 128 costs and walks the stored edges one edge per cycle.
// Reset empties the edge list at once; the memories need no clearing pass.
// The receiver cannot stall; busy alone holds off new requests during a query.
`timescale 1ns / 1ps
`default_nettype none

module hop_limited_shortest_path_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hlsp_pkg::CMD_W-1:0]    in_command,
  input  logic [hlsp_pkg::CITY_W-1:0]   in_edge_from,
  input  logic [hlsp_pkg::CITY_W-1:0]   in_edge_to,
  input  logic [hlsp_pkg::PRICE_W-1:0]  in_edge_price,
  input  logic [hlsp_pkg::CITY_W-1:0]   in_source_city,
  input  logic [hlsp_pkg::CITY_W-1:0]   in_target_city,
  input  logic [hlsp_pkg::STOPS_W-1:0]  in_max_stops,
  output logic                          out_valid,
  output logic [hlsp_pkg::COST_W-1:0]   out_path_cost,
  output logic                          out_found,
  output logic                          out_edge_overflow
);
  import hlsp_pkg::*;

  logic                 accept;
  edge_t                edge_in;
  edge_t                edge_rdata;
  logic [EDGE_AW-1:0]   edge_raddr;
  edge_stat_t           stat;
  query_req_t           req;

  assign accept = start && !busy;

  assign edge_in.from_city = in_edge_from;
  assign edge_in.to_city   = in_edge_to;
  assign edge_in.price     = in_edge_price;

  assign req.valid = accept && (in_command == CMD_QUERY);
  assign req.src   = in_source_city;
  assign req.dst   = in_target_city;
  assign req.stops = in_max_stops;

  hlsp_edge_list u_edge_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (accept),
    .cmd       (cmd_t'(in_command)),
    .edge_in   (edge_in),
    .rd_addr   (edge_raddr),
    .rd_data   (edge_rdata),
    .stat      (stat)
  );

  hlsp_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .stat              (stat),
    .edge_raddr        (edge_raddr),
    .edge_rdata        (edge_rdata),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_path_cost     (out_path_cost),
    .out_found         (out_found),
    .out_edge_overflow (out_edge_overflow)
  );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the hop-limited shortest path block.
`timescale 1ns / 1ps

module tb;
  import hlsp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1200;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CITY_W-1:0]  from_c;
    logic [CITY_W-1:0]  to_c;
    logic [PRICE_W-1:0] price;
    logic [CITY_W-1:0]  src;
    logic [CITY_W-1:0]  dst;
    logic [STOPS_W-1:0] stops;
    logic               known;
    logic [COST_W-1:0]  cost;
    logic               found;
    logic               ovf;
  } req_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              found;
    logic              ovf;
  } fare_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [CITY_W-1:0]   in_edge_from;
  logic [CITY_W-1:0]   in_edge_to;
  logic [PRICE_W-1:0]  in_edge_price;
  logic [CITY_W-1:0]   in_source_city;
  logic [CITY_W-1:0]   in_target_city;
  logic [STOPS_W-1:0]  in_max_stops;
  logic                out_valid;
  logic [COST_W-1:0]   out_path_cost;
  logic                out_found;
  logic                out_edge_overflow;

  logic [CITY_W-1:0]  leg_from [MAX_EDGES];
  logic [CITY_W-1:0]  leg_to [MAX_EDGES];
  logic [PRICE_W-1:0] leg_price [MAX_EDGES];
  int                 leg_count;
  logic               legs_dropped;

  fare_t fare_due [$];
  int    bad_count;
  int    request_count;
  int    burst_left;

  hop_limited_shortest_path_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_edge_price     (in_edge_price),
    .in_source_city    (in_source_city),
    .in_target_city    (in_target_city),
    .in_max_stops      (in_max_stops),
    .out_valid         (out_valid),
    .out_path_cost     (out_path_cost),
    .out_found         (out_found),
    .out_edge_overflow (out_edge_overflow)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [COST_W-1:0] cheapest_fare(input logic [CITY_W-1:0] src,
      input logic [CITY_W-1:0] dst, input logic [STOPS_W-1:0] stops, output logic reached);
    logic [COST_W-1:0] cost_now [CITIES];
    logic [COST_W-1:0] cost_next [CITIES];
    bit                seen_now [CITIES];
    bit                seen_next [CITIES];
    logic [COST_W:0]   trial;
    bit                improved;
    if (src == dst) begin
      reached = 1'b1;
      return '0;
    end
    foreach (cost_now[c]) begin
      cost_now[c] = '0;
      seen_now[c] = 1'b0;
    end
    seen_now[src] = 1'b1;
    for (int r = 0; r <= int'(stops); r++) begin
      cost_next = cost_now;
      seen_next = seen_now;
      improved = 1'b0;
      for (int e = 0; e < leg_count; e++) begin
        if (seen_now[leg_from[e]]) begin
          trial = cost_now[leg_from[e]] + leg_price[e];
          if (trial > COST_MAX) trial = COST_MAX;
          if (!seen_next[leg_to[e]] || trial[COST_W-1:0] < cost_next[leg_to[e]]) begin
            cost_next[leg_to[e]] = trial[COST_W-1:0];
            seen_next[leg_to[e]] = 1'b1;
            improved = 1'b1;
          end
        end
      end
      cost_now = cost_next;
      seen_now = seen_next;
      if (!improved) break;
    end
    reached = seen_now[dst];
    return reached ? cost_now[dst] : '0;
  endfunction

  // Updates the edge list and returns 1 when the request produces a result.
  function automatic bit apply_request(input req_t r, output fare_t f);
    f = '0;
    case (r.command)
      CMD_CLEAR: begin
        leg_count = 0;
        legs_dropped = 1'b0;
      end
      CMD_ADD: begin
        if (leg_count < MAX_EDGES) begin
          leg_from[leg_count] = r.from_c;
          leg_to[leg_count] = r.to_c;
          leg_price[leg_count] = r.price;
          leg_count++;
        end else begin
          legs_dropped = 1'b1;
        end
      end
      CMD_QUERY: begin
        f.cost = cheapest_fare(r.src, r.dst, r.stops, f.found);
        f.ovf = legs_dropped;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic req_t scrambled(input logic [CMD_W-1:0] command);
    req_t r;
    r = '0;
    r.command = command;
    r.from_c = CITY_W'($urandom);
    r.to_c = CITY_W'($urandom);
    r.price = PRICE_W'($urandom);
    r.src = CITY_W'($urandom);
    r.dst = CITY_W'($urandom);
    r.stops = STOPS_W'($urandom);
    return r;
  endfunction

  function automatic logic [CITY_W-1:0] near_city(input int base, input int span);
    return CITY_W'((base + $urandom_range(0, span - 1)) % CITIES);
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PRICE_W'($urandom_range(0, (1 << PRICE_W) - 1));
    endcase
  endfunction

  function automatic logic [STOPS_W-1:0] pick_stops();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return STOPS_W'($urandom_range(0, 7));
    if (roll < 19) return STOPS_W'($urandom_range(8, 31));
    return STOPS_W'($urandom_range(32, (1 << STOPS_W) - 1));
  endfunction

  task automatic sender_pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic post_request(input req_t r);
    fare_t f;
    sender_pace();
    in_command <= r.command;
    in_edge_from <= r.from_c;
    in_edge_to <= r.to_c;
    in_edge_price <= r.price;
    in_source_city <= r.src;
    in_target_city <= r.dst;
    in_max_stops <= r.stops;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (r.command != CMD_UNUSED) request_count++;
    if (apply_request(r, f)) begin
      if (r.known) f = '{r.cost, r.found, r.ovf};
      fare_due = {fare_due, f};
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (fare_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    fare_t want;
    if (rst_n && out_valid) begin
      if (fare_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("Unexpected result: cost %0d found %0b overflow %0b",
                   out_path_cost, out_found, out_edge_overflow);
      end else begin
        want = fare_due.pop_front();
        if (out_path_cost !== want.cost || out_found !== want.found ||
            out_edge_overflow !== want.ovf) begin
          bad_count++;
          if (bad_count <= 10)
            $display("Result mismatch: expected cost %0d found %0b overflow %0b, got %0d %0b %0b",
                     want.cost, want.found, want.ovf,
                     out_path_cost, out_found, out_edge_overflow);
        end
      end
    end
  end

  initial begin
    repeat (4) #1_000_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    req_t directed_rows [25];
    req_t r;
    int   base;
    int   span;
    int   n_add;
    int   n_ask;
    int   goal;
    directed_rows = '{
      '{CMD_QUERY,    0,   0,     0,   5,   9,   0, 1,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   0,   0, 1,       0, 1, 0},
      '{CMD_QUERY,    0,   0,     0, 127, 127, 127, 1,       0, 1, 0},
      '{CMD_UNUSED, 127, 127, 16383, 127, 127, 127, 0,       0, 0, 0},
      '{CMD_ADD,      0,   1,     0,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_ADD,      1,   2, 16383,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_ADD,      2, 127,     1,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_ADD,    127,   0, 10000,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   1,   0, 1,       0, 1, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   2,   0, 1,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   2,   1, 1,   16383, 1, 0},
      '{CMD_QUERY,    0,   0,     0,   0, 127, 127, 1,   16384, 1, 0},
      '{CMD_QUERY,    0,   0,     0, 127,   2,   1, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0, 127,   2,   2, 0,       0, 0, 0},
      '{CMD_ADD,      0,   2,  5000,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   2,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   2,   1, 0,       0, 0, 0},
      '{CMD_ADD,      5,   5,     7,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   5,   6,   3, 0,       0, 0, 0},
      '{CMD_UNUSED,   0,   0,     0,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   2,   0, 127, 0,       0, 0, 0},
      '{CMD_CLEAR,    0,   0,     0,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0,   0,   1, 127, 1,       0, 0, 0},
      '{CMD_ADD,    127, 126, 16383,   0,   0,   0, 0,       0, 0, 0},
      '{CMD_QUERY,    0,   0,     0, 127, 126,   0, 1,   16383, 1, 0}
    };
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_CLEAR;
    in_edge_from <= '0;
    in_edge_to <= '0;
    in_edge_price <= '0;
    in_source_city <= '0;
    in_target_city <= '0;
    in_max_stops <= '0;
    leg_count = 0;
    legs_dropped = 1'b0;
    bad_count = 0;
    request_count = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) post_request(directed_rows[i]);
    drain_results();

    // A full-price chain through every city exercises the longest stop limit.
    post_request(scrambled(CMD_CLEAR));
    for (int c = 0; c < CITIES - 1; c++) begin
      r = scrambled(CMD_ADD);
      r.from_c = CITY_W'(c);
      r.to_c = CITY_W'(c + 1);
      r.price = '1;
      post_request(r);
    end
    r = scrambled(CMD_ADD);
    r.from_c = CITY_W'(CITIES - 1);
    r.to_c = '0;
    r.price = '0;
    post_request(r);
    r = scrambled(CMD_QUERY);
    r.src = '0;
    r.dst = CITY_W'(CITIES - 1);
    r.stops = '1;
    post_request(r);
    r.stops = STOPS_W'(CITIES - 3);
    post_request(r);
    r.src = CITY_W'(1);
    r.dst = '0;
    r.stops = '1;
    post_request(r);
    drain_results();

    // Fill the edge list to capacity, then push past it.
    post_request(scrambled(CMD_CLEAR));
    repeat (MAX_EDGES + 2) post_request(scrambled(CMD_ADD));
    r = scrambled(CMD_QUERY);
    r.stops = STOPS_W'(1);
    post_request(r);
    r.dst = r.src;
    post_request(r);
    r = scrambled(CMD_QUERY);
    r.stops = '0;
    post_request(r);
    post_request(scrambled(CMD_CLEAR));
    post_request(scrambled(CMD_QUERY));
    drain_results();

    goal = request_count + RANDOM_REQUESTS;
    while (request_count < goal) begin
      if (leg_count > 48 || $urandom_range(0, 3) != 0) post_request(scrambled(CMD_CLEAR));
      base = $urandom_range(0, CITIES - 1);
      span = $urandom_range(2, 16);
      n_add = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      n_ask = $urandom_range(1, 6);
      repeat (n_add) begin
        r = scrambled(CMD_ADD);
        r.from_c = near_city(base, span);
        r.to_c = near_city(base, span);
        r.price = pick_price();
        post_request(r);
      end
      repeat (n_ask) begin
        case ($urandom_range(0, 19))
          0: r = scrambled(CMD_UNUSED);
          1: begin
            r = scrambled(CMD_ADD);
            r.from_c = near_city(base, span);
            r.price = pick_price();
          end
          2, 3: r = scrambled(CMD_QUERY);
          default: begin
            r = scrambled(CMD_QUERY);
            r.src = near_city(base, span);
            r.dst = ($urandom_range(0, 9) == 0) ? r.src : near_city(base, span);
            r.stops = pick_stops();
          end
        endcase
        post_request(r);
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    start <= 1'b0;
    while (fare_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
